[src/dahdsr_pkg.sv]
`default_nettype none

package dahdsr_pkg;

  localparam int unsigned OffsetBits = 24;
  localparam int unsigned LenBits    = 16;
  localparam int unsigned LevelBits  = 15;
  localparam int unsigned StageBits  = 3;
  localparam int unsigned CfgIdxBits = 3;
  // six lengths summed stay below 2^19
  localparam int unsigned BoundBits  = LenBits + 3;
  localparam int unsigned CmpBits    = (OffsetBits > BoundBits) ? OffsetBits : BoundBits;
  localparam int unsigned NumBits    = LenBits + LevelBits;
  localparam int unsigned QuoBits    = LevelBits;

  localparam logic [LevelBits-1:0] FullScale = LevelBits'(16384);

  localparam logic [LenBits-1:0]   DelayRst   = LenBits'(20);
  localparam logic [LenBits-1:0]   AttackRst  = LenBits'(120);
  localparam logic [LenBits-1:0]   HoldRst    = LenBits'(70);
  localparam logic [LenBits-1:0]   DecayRst   = LenBits'(175);
  localparam logic [LenBits-1:0]   SustainRst = LenBits'(300);
  localparam logic [LenBits-1:0]   ReleaseRst = LenBits'(300);
  localparam logic [LevelBits-1:0] LevelRst   = LevelBits'(8192);

  typedef enum logic [StageBits-1:0] {
    StDelay   = 3'd0,
    StAttack  = 3'd1,
    StHold    = 3'd2,
    StDecay   = 3'd3,
    StSustain = 3'd4,
    StRelease = 3'd5
  } stage_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegDelay        = 3'd0,
    RegAttack       = 3'd1,
    RegHold         = 3'd2,
    RegDecay        = 3'd3,
    RegSustain      = 3'd4,
    RegRelease      = 3'd5,
    RegSustainLevel = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LenBits-1:0]   delay_len;
    logic [LenBits-1:0]   attack_len;
    logic [LenBits-1:0]   hold_len;
    logic [LenBits-1:0]   decay_len;
    logic [LenBits-1:0]   sustain_len;
    logic [LenBits-1:0]   release_len;
    logic [LevelBits-1:0] sus_level;
  } cfg_t;

  // side information that travels alongside the arithmetic
  typedef struct packed {
    stage_e               stage;
    logic                 in_note;
    logic                 direct;
    logic [LevelBits-1:0] direct_val;
    logic                 invert;
  } ctl_t;

  function automatic logic [LevelBits-1:0] clamp_level(input logic [LevelBits-1:0] level);
    clamp_level = (level > FullScale) ? FullScale : level;
  endfunction

endpackage

`default_nettype wire

[src/dahdsr_envelope_generator.sv]
`default_nettype none

// channel   direction  handshake               payload
// in        sink       in_valid_i / in_stall_o  sample_offset_i, note_length_i
// out       source     out_valid_o / out_stall_i envelope_o, in_note_o, stage_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle unless a waiting result is stalled; 2 classify, 2 multiply-add,
// 15 divider stages (one quotient bit each), 1 output register.
// reset loads the default lengths and level and empties the pipeline.
// a stalled full output register freezes every stage; in_stall_o follows it.
// cfg is always ready; index 7 is ignored.

module dahdsr_envelope_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dahdsr_pkg::OffsetBits-1:0] sample_offset_i,
  input  logic [dahdsr_pkg::OffsetBits-1:0] note_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dahdsr_pkg::LevelBits-1:0]  envelope_o,
  output logic                              in_note_o,
  output logic [dahdsr_pkg::StageBits-1:0]  stage_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dahdsr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [dahdsr_pkg::LenBits-1:0]    cfg_data_i
);

  logic [dahdsr_pkg::LenBits-1:0]   delay_q, attack_q, hold_q, decay_q, sustain_q, release_q;
  logic [dahdsr_pkg::LevelBits-1:0] level_q;
  dahdsr_pkg::cfg_t                 cfg;
  logic                             en;

  logic                             f_valid, m_valid, d_valid;
  dahdsr_pkg::ctl_t                 f_ctl, m_ctl, d_ctl;
  logic [dahdsr_pkg::LenBits-1:0]   f_op_a, f_divisor, f_addend, m_divisor;
  logic [dahdsr_pkg::LevelBits-1:0] f_op_m;
  logic [dahdsr_pkg::NumBits-1:0]   m_num;
  logic [dahdsr_pkg::QuoBits-1:0]   d_quo;

  logic                             out_valid_q, in_note_q;
  logic [dahdsr_pkg::LevelBits-1:0] env_d, env_q;
  dahdsr_pkg::stage_e               stage_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= dahdsr_pkg::DelayRst;
      attack_q  <= dahdsr_pkg::AttackRst;
      hold_q    <= dahdsr_pkg::HoldRst;
      decay_q   <= dahdsr_pkg::DecayRst;
      sustain_q <= dahdsr_pkg::SustainRst;
      release_q <= dahdsr_pkg::ReleaseRst;
      level_q   <= dahdsr_pkg::LevelRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dahdsr_pkg::cfg_reg_e'(cfg_index_i))
        dahdsr_pkg::RegDelay:        delay_q   <= cfg_data_i;
        dahdsr_pkg::RegAttack:       attack_q  <= cfg_data_i;
        dahdsr_pkg::RegHold:         hold_q    <= cfg_data_i;
        dahdsr_pkg::RegDecay:        decay_q   <= cfg_data_i;
        dahdsr_pkg::RegSustain:      sustain_q <= cfg_data_i;
        dahdsr_pkg::RegRelease:      release_q <= cfg_data_i;
        dahdsr_pkg::RegSustainLevel: level_q   <= dahdsr_pkg::LevelBits'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.delay_len   = delay_q;
    cfg.attack_len  = attack_q;
    cfg.hold_len    = hold_q;
    cfg.decay_len   = decay_q;
    cfg.sustain_len = sustain_q;
    cfg.release_len = release_q;
    cfg.sus_level   = level_q;
  end

  // whole pipeline moves unless a result is waiting and held off
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  dahdsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cfg_i           (cfg),
    .valid_i         (in_valid_i),
    .sample_offset_i (sample_offset_i),
    .note_length_i   (note_length_i),
    .valid_o         (f_valid),
    .ctl_o           (f_ctl),
    .op_a_o          (f_op_a),
    .op_m_o          (f_op_m),
    .divisor_o       (f_divisor),
    .addend_o        (f_addend)
  );

  dahdsr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (f_valid),
    .ctl_i     (f_ctl),
    .op_a_i    (f_op_a),
    .op_m_i    (f_op_m),
    .divisor_i (f_divisor),
    .addend_i  (f_addend),
    .valid_o   (m_valid),
    .ctl_o     (m_ctl),
    .num_o     (m_num),
    .divisor_o (m_divisor)
  );

  dahdsr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (m_valid),
    .ctl_i     (m_ctl),
    .num_i     (m_num),
    .divisor_i (m_divisor),
    .valid_o   (d_valid),
    .ctl_o     (d_ctl),
    .quo_o     (d_quo)
  );

  always_comb begin
    if (d_ctl.direct) begin
      env_d = d_ctl.direct_val;
    end else if (d_ctl.invert) begin
      env_d = dahdsr_pkg::FullScale - d_quo;
    end else begin
      env_d = d_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      env_q     <= env_d;
      in_note_q <= d_ctl.in_note;
      stage_q   <= d_ctl.stage;
    end
  end

  assign out_valid_o = out_valid_q;
  assign envelope_o  = env_q;
  assign in_note_o   = in_note_q;
  assign stage_o     = stage_q;

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> envelope_o <= dahdsr_pkg::FullScale)
    else $error("envelope above full scale");

  a_delay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stage_o == dahdsr_pkg::StDelay) |-> envelope_o == '0)
    else $error("delay stage with nonzero envelope");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stage_o == dahdsr_pkg::StHold) |-> envelope_o == dahdsr_pkg::FullScale)
    else $error("hold stage not at full scale");

  a_sustain_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stage_o == dahdsr_pkg::StSustain)
      |-> envelope_o == dahdsr_pkg::clamp_level(level_q))
    else $error("sustain stage off the sustain level");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input held off without a waiting result");

endmodule

`default_nettype wire

[src/dahdsr_front.sv]
`default_nettype none

module dahdsr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  dahdsr_pkg::cfg_t                    cfg_i,
  input  logic                                valid_i,
  input  logic [dahdsr_pkg::OffsetBits-1:0]   sample_offset_i,
  input  logic [dahdsr_pkg::OffsetBits-1:0]   note_length_i,
  output logic                                valid_o,
  output dahdsr_pkg::ctl_t                    ctl_o,
  output logic [dahdsr_pkg::LenBits-1:0]      op_a_o,
  output logic [dahdsr_pkg::LevelBits-1:0]    op_m_o,
  output logic [dahdsr_pkg::LenBits-1:0]      divisor_o,
  output logic [dahdsr_pkg::LenBits-1:0]      addend_o
);

  localparam int unsigned NumBounds = 6;

  logic [dahdsr_pkg::BoundBits-1:0]  p12, p34, p56;
  logic [dahdsr_pkg::BoundBits-1:0]  bnd_d [NumBounds];
  logic [dahdsr_pkg::BoundBits-1:0]  bnd_q [NumBounds];
  logic [dahdsr_pkg::OffsetBits-1:0] t_q, len_q;
  logic                              va_q;

  logic [dahdsr_pkg::CmpBits-1:0]    tc;
  logic [NumBounds-1:0]              lt;
  logic [dahdsr_pkg::CmpBits-1:0]    diff_att, diff_dec, diff_rel;
  logic [dahdsr_pkg::LevelBits-1:0]  level;

  dahdsr_pkg::ctl_t                  ctl_d, ctl_q;
  logic [dahdsr_pkg::LenBits-1:0]    op_a_d, op_a_q, divisor_d, divisor_q, addend_d, addend_q;
  logic [dahdsr_pkg::LevelBits-1:0]  op_m_d, op_m_q;
  logic                              vb_q;

  // stage boundaries as a shallow adder tree
  always_comb begin
    p12 = dahdsr_pkg::BoundBits'(cfg_i.delay_len) + dahdsr_pkg::BoundBits'(cfg_i.attack_len);
    p34 = dahdsr_pkg::BoundBits'(cfg_i.hold_len) + dahdsr_pkg::BoundBits'(cfg_i.decay_len);
    p56 = dahdsr_pkg::BoundBits'(cfg_i.sustain_len) + dahdsr_pkg::BoundBits'(cfg_i.release_len);
    bnd_d[0] = dahdsr_pkg::BoundBits'(cfg_i.delay_len);
    bnd_d[1] = p12;
    bnd_d[2] = p12 + dahdsr_pkg::BoundBits'(cfg_i.hold_len);
    bnd_d[3] = p12 + p34;
    bnd_d[4] = bnd_d[3] + dahdsr_pkg::BoundBits'(cfg_i.sustain_len);
    bnd_d[5] = bnd_d[3] + p56;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= sample_offset_i;
      len_q <= note_length_i;
      bnd_q <= bnd_d;
    end
  end

  always_comb begin
    tc = dahdsr_pkg::CmpBits'(t_q);
    for (int i = 0; i < NumBounds; i++) begin
      lt[i] = tc < dahdsr_pkg::CmpBits'(bnd_q[i]);
    end
    diff_att = tc - dahdsr_pkg::CmpBits'(bnd_q[0]);
    diff_dec = tc - dahdsr_pkg::CmpBits'(bnd_q[2]);
    // release remaining = end of release minus t
    diff_rel = dahdsr_pkg::CmpBits'(bnd_q[5]) - tc;
    level    = dahdsr_pkg::clamp_level(cfg_i.sus_level);
  end

  always_comb begin
    ctl_d.stage      = dahdsr_pkg::StDelay;
    ctl_d.in_note    = t_q < len_q;
    ctl_d.direct     = 1'b1;
    ctl_d.direct_val = '0;
    ctl_d.invert     = 1'b0;
    op_a_d           = '0;
    op_m_d           = '0;
    divisor_d        = cfg_i.attack_len;
    addend_d         = '0;
    priority if (lt[0]) begin
      ctl_d.stage = dahdsr_pkg::StDelay;
    end else if (lt[1]) begin
      ctl_d.stage  = dahdsr_pkg::StAttack;
      ctl_d.direct = 1'b0;
      op_a_d       = dahdsr_pkg::LenBits'(diff_att);
      op_m_d       = dahdsr_pkg::FullScale;
      divisor_d    = cfg_i.attack_len;
    end else if (lt[2]) begin
      ctl_d.stage      = dahdsr_pkg::StHold;
      ctl_d.direct_val = dahdsr_pkg::FullScale;
    end else if (lt[3]) begin
      // ceiling of the drop, taken away from full scale at the end
      ctl_d.stage  = dahdsr_pkg::StDecay;
      ctl_d.direct = 1'b0;
      ctl_d.invert = 1'b1;
      op_a_d       = dahdsr_pkg::LenBits'(diff_dec);
      op_m_d       = dahdsr_pkg::FullScale - level;
      divisor_d    = cfg_i.decay_len;
      addend_d     = cfg_i.decay_len - dahdsr_pkg::LenBits'(1);
    end else if (lt[4]) begin
      ctl_d.stage      = dahdsr_pkg::StSustain;
      ctl_d.direct_val = level;
    end else begin
      ctl_d.stage  = dahdsr_pkg::StRelease;
      ctl_d.direct = !lt[5];
      op_a_d       = dahdsr_pkg::LenBits'(diff_rel);
      op_m_d       = level;
      divisor_d    = cfg_i.release_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q     <= ctl_d;
      op_a_q    <= op_a_d;
      op_m_q    <= op_m_d;
      divisor_q <= divisor_d;
      addend_q  <= addend_d;
    end
  end

  assign valid_o   = vb_q;
  assign ctl_o     = ctl_q;
  assign op_a_o    = op_a_q;
  assign op_m_o    = op_m_q;
  assign divisor_o = divisor_q;
  assign addend_o  = addend_q;

endmodule

`default_nettype wire

[src/dahdsr_mul.sv]
`default_nettype none

module dahdsr_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  dahdsr_pkg::ctl_t                 ctl_i,
  input  logic [dahdsr_pkg::LenBits-1:0]   op_a_i,
  input  logic [dahdsr_pkg::LevelBits-1:0] op_m_i,
  input  logic [dahdsr_pkg::LenBits-1:0]   divisor_i,
  input  logic [dahdsr_pkg::LenBits-1:0]   addend_i,
  output logic                             valid_o,
  output dahdsr_pkg::ctl_t                 ctl_o,
  output logic [dahdsr_pkg::NumBits-1:0]   num_o,
  output logic [dahdsr_pkg::LenBits-1:0]   divisor_o
);

  logic                           vc_q, vd_q;
  logic [dahdsr_pkg::NumBits-1:0] prod_q, num_q;
  logic [dahdsr_pkg::LenBits-1:0] addend_q, div_c_q, div_d_q;
  dahdsr_pkg::ctl_t               ctl_c_q, ctl_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= valid_i;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= dahdsr_pkg::NumBits'(op_a_i) * dahdsr_pkg::NumBits'(op_m_i);
      addend_q <= addend_i;
      div_c_q  <= divisor_i;
      ctl_c_q  <= ctl_i;
      // rounding term for the decay ceiling
      num_q    <= prod_q + dahdsr_pkg::NumBits'(addend_q);
      div_d_q  <= div_c_q;
      ctl_d_q  <= ctl_c_q;
    end
  end

  assign valid_o   = vd_q;
  assign ctl_o     = ctl_d_q;
  assign num_o     = num_q;
  assign divisor_o = div_d_q;

endmodule

`default_nettype wire

[src/dahdsr_div.sv]
`default_nettype none

module dahdsr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  dahdsr_pkg::ctl_t                 ctl_i,
  input  logic [dahdsr_pkg::NumBits-1:0]   num_i,
  input  logic [dahdsr_pkg::LenBits-1:0]   divisor_i,
  output logic                             valid_o,
  output dahdsr_pkg::ctl_t                 ctl_o,
  output logic [dahdsr_pkg::QuoBits-1:0]   quo_o
);

  localparam int unsigned Depth = dahdsr_pkg::QuoBits;

  logic                           valid_q [Depth];
  logic [dahdsr_pkg::NumBits-1:0] rem_q   [Depth];
  logic [dahdsr_pkg::QuoBits-1:0] quo_q   [Depth];
  logic [dahdsr_pkg::LenBits-1:0] div_q   [Depth];
  dahdsr_pkg::ctl_t               ctl_q   [Depth];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < Depth; k++) begin : g_stage
    localparam int unsigned Shift = Depth - 1 - k;

    logic                           valid_prev;
    logic [dahdsr_pkg::NumBits-1:0] rem_prev, trial;
    logic [dahdsr_pkg::QuoBits-1:0] quo_prev;
    logic [dahdsr_pkg::LenBits-1:0] div_prev;
    dahdsr_pkg::ctl_t               ctl_prev;
    logic                           fits;

    if (k == 0) begin : g_first
      assign valid_prev = valid_i;
      assign rem_prev   = num_i;
      assign quo_prev   = '0;
      assign div_prev   = divisor_i;
      assign ctl_prev   = ctl_i;
    end else begin : g_next
      assign valid_prev = valid_q[k-1];
      assign rem_prev   = rem_q[k-1];
      assign quo_prev   = quo_q[k-1];
      assign div_prev   = div_q[k-1];
      assign ctl_prev   = ctl_q[k-1];
    end

    assign trial = dahdsr_pkg::NumBits'(div_prev) << Shift;
    assign fits  = rem_prev >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? (rem_prev - trial) : rem_prev;
        quo_q[k] <= quo_prev | (dahdsr_pkg::QuoBits'(fits) << Shift);
        div_q[k] <= div_prev;
        ctl_q[k] <= ctl_prev;
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign ctl_o   = ctl_q[Depth-1];
  assign quo_o   = quo_q[Depth-1];

endmodule

`default_nettype wire

[dv/dahdsr_envelope_generator_test.sv]
`default_nettype none

module dahdsr_envelope_generator_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dahdsr_pkg::CfgIdxBits-1:0] RegUnused = 3'd7;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldOffCycles = 200;

  typedef struct packed {
    logic [dahdsr_pkg::LevelBits-1:0] envelope;
    logic                             in_note;
    dahdsr_pkg::stage_e               stage;
  } env_result_t;

  typedef struct packed {
    logic [dahdsr_pkg::OffsetBits-1:0] offset;
    logic [dahdsr_pkg::OffsetBits-1:0] length;
    logic                              typed;
    env_result_t                       res;
  } dir_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [dahdsr_pkg::OffsetBits-1:0] sample_offset_i;
  logic [dahdsr_pkg::OffsetBits-1:0] note_length_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [dahdsr_pkg::LevelBits-1:0]  envelope_o;
  logic                              in_note_o;
  logic [dahdsr_pkg::StageBits-1:0]  stage_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [dahdsr_pkg::CfgIdxBits-1:0] cfg_index_i;
  logic [dahdsr_pkg::LenBits-1:0]    cfg_data_i;

  dahdsr_pkg::cfg_t model_cfg;
  env_result_t      env_due_q[$];
  dir_row_t         dir_rows [22];
  int unsigned      err_cnt;
  int unsigned      idle_cycles;
  int unsigned      tx_rush;
  bit               tx_calm;
  bit               rx_calm;
  bit               hold_req;

  dahdsr_envelope_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_offset_i(sample_offset_i),
    .note_length_i  (note_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .envelope_o     (envelope_o),
    .in_note_o      (in_note_o),
    .stage_o        (stage_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // envelope level, stage and note flag for one sample under the shadow registers
  function automatic env_result_t envelope_of(
      input logic [dahdsr_pkg::OffsetBits-1:0] offset,
      input logic [dahdsr_pkg::OffsetBits-1:0] length);
    longint unsigned t, s, full, b1, b2, b3, b4, b5, d, drop, lvl;
    env_result_t r;
    full = dahdsr_pkg::FullScale;
    t    = offset;
    s    = model_cfg.sus_level;
    if (s > full) s = full;
    b1 = model_cfg.delay_len;
    b2 = b1 + model_cfg.attack_len;
    b3 = b2 + model_cfg.hold_len;
    b4 = b3 + model_cfg.decay_len;
    b5 = b4 + model_cfg.sustain_len;
    if (t < b1) begin
      r.stage = dahdsr_pkg::StDelay;
      lvl = 0;
    end else if (t < b2) begin
      r.stage = dahdsr_pkg::StAttack;
      lvl = ((t - b1) * full) / model_cfg.attack_len;
    end else if (t < b3) begin
      r.stage = dahdsr_pkg::StHold;
      lvl = full;
    end else if (t < b4) begin
      r.stage = dahdsr_pkg::StDecay;
      // drop rounds up so the level is the floor of the falling ramp
      drop = ((full - s) * (t - b3) + model_cfg.decay_len - 1) / model_cfg.decay_len;
      lvl = full - drop;
    end else if (t < b5) begin
      r.stage = dahdsr_pkg::StSustain;
      lvl = s;
    end else begin
      r.stage = dahdsr_pkg::StRelease;
      d = t - b5;
      if (model_cfg.release_len == 0 || d >= model_cfg.release_len) lvl = 0;
      else lvl = (s * (model_cfg.release_len - d)) / model_cfg.release_len;
    end
    r.envelope = lvl[dahdsr_pkg::LevelBits-1:0];
    r.in_note  = (offset < length);
    return r;
  endfunction

  function automatic logic [dahdsr_pkg::OffsetBits-1:0] pick_offset();
    longint unsigned bnd [7];
    longint signed t;
    bnd[0] = 0;
    bnd[1] = model_cfg.delay_len;
    bnd[2] = bnd[1] + model_cfg.attack_len;
    bnd[3] = bnd[2] + model_cfg.hold_len;
    bnd[4] = bnd[3] + model_cfg.decay_len;
    bnd[5] = bnd[4] + model_cfg.sustain_len;
    bnd[6] = bnd[5] + model_cfg.release_len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: t = $urandom_range(0, 32'(bnd[6] + 4));
      6, 7: begin
        // land on or right beside a stage boundary
        t = longint'(bnd[$urandom_range(0, 6)]) + longint'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
      end
      default: t = $urandom() & 32'hFF_FFFF;
    endcase
    return dahdsr_pkg::OffsetBits'(t);
  endfunction

  function automatic logic [dahdsr_pkg::OffsetBits-1:0] pick_length(
      input logic [dahdsr_pkg::OffsetBits-1:0] offset);
    longint unsigned span;
    span = longint'(model_cfg.delay_len) + model_cfg.attack_len + model_cfg.hold_len
         + model_cfg.decay_len + model_cfg.sustain_len + model_cfg.release_len;
    case ($urandom_range(0, 2))
      0: return dahdsr_pkg::OffsetBits'($urandom());
      1: return offset + dahdsr_pkg::OffsetBits'($urandom_range(0, 2))
                - dahdsr_pkg::OffsetBits'(1);
      default: return dahdsr_pkg::OffsetBits'($urandom_range(0, 32'(span + 4)));
    endcase
  endfunction

  function automatic logic [dahdsr_pkg::LenBits-1:0] rand_len();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3: return dahdsr_pkg::LenBits'($urandom_range(1, 8));
      4: return dahdsr_pkg::LenBits'($urandom());
      default: return dahdsr_pkg::LenBits'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [dahdsr_pkg::LenBits-1:0] rand_level_data();
    logic [dahdsr_pkg::LenBits-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'd0;
      1: v = 16'd16384;
      2: v = 16'd16385;
      3: v = 16'h7FFF;
      4: v = dahdsr_pkg::LenBits'($urandom_range(0, 16384));
      default: v = dahdsr_pkg::LenBits'($urandom());
    endcase
    // top bit lies outside the level register
    v[dahdsr_pkg::LenBits-1] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic send_sample(input logic [dahdsr_pkg::OffsetBits-1:0] offset,
                             input logic [dahdsr_pkg::OffsetBits-1:0] length,
                             input logic typed, input env_result_t typed_res);
    int unsigned gap;
    gap = (tx_calm || tx_rush > 0) ? 0 : $urandom_range(0, 19);
    if (tx_rush > 0) tx_rush--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_offset_i <= offset;
    note_length_i   <= length;
    do @(posedge clk_i); while (in_stall_o);
    env_due_q.push_back(typed ? typed_res : envelope_of(offset, length));
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (env_due_q.size() != 0) @(posedge clk_i);
  endtask

  // writes every register once, with a write to the unused index at a random slot
  task automatic load_config(input dahdsr_pkg::cfg_t c,
                             input logic [dahdsr_pkg::LenBits-1:0] level_data);
    int unsigned slot, j;
    logic [dahdsr_pkg::CfgIdxBits-1:0] idx;
    logic [dahdsr_pkg::LenBits-1:0] data;
    slot = $urandom_range(0, 7);
    for (j = 0; j < 8; j++) begin
      if (j == slot) idx = RegUnused;
      else idx = (j < slot) ? dahdsr_pkg::CfgIdxBits'(j) : dahdsr_pkg::CfgIdxBits'(j - 1);
      case (idx)
        dahdsr_pkg::RegDelay:        data = c.delay_len;
        dahdsr_pkg::RegAttack:       data = c.attack_len;
        dahdsr_pkg::RegHold:         data = c.hold_len;
        dahdsr_pkg::RegDecay:        data = c.decay_len;
        dahdsr_pkg::RegSustain:      data = c.sustain_len;
        dahdsr_pkg::RegRelease:      data = c.release_len;
        dahdsr_pkg::RegSustainLevel: data = level_data;
        default:                     data = dahdsr_pkg::LenBits'($urandom());
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        dahdsr_pkg::RegDelay:        model_cfg.delay_len   = data;
        dahdsr_pkg::RegAttack:       model_cfg.attack_len  = data;
        dahdsr_pkg::RegHold:         model_cfg.hold_len    = data;
        dahdsr_pkg::RegDecay:        model_cfg.decay_len   = data;
        dahdsr_pkg::RegSustain:      model_cfg.sustain_len = data;
        dahdsr_pkg::RegRelease:      model_cfg.release_len = data;
        dahdsr_pkg::RegSustainLevel: model_cfg.sus_level   = data[dahdsr_pkg::LevelBits-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input int hold_at);
    int unsigned i;
    logic [dahdsr_pkg::OffsetBits-1:0] off;
    for (i = 0; i < n; i++) begin
      if (int'(i) == hold_at) begin
        // sink holds off while requests keep coming back to back
        hold_req = 1'b1;
        tx_rush  = 60;
      end
      off = pick_offset();
      send_sample(off, pick_length(off), 1'b0, '0);
    end
  endtask

  initial begin : main_seq
    dahdsr_pkg::cfg_t c;
    logic [dahdsr_pkg::LenBits-1:0] lvl;
    int unsigned p, k;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    sample_offset_i <= '0;
    note_length_i   <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    err_cnt  = 0;
    tx_rush  = 0;
    tx_calm  = 1'b0;
    hold_req = 1'b0;
    model_cfg = '{delay_len: dahdsr_pkg::DelayRst, attack_len: dahdsr_pkg::AttackRst,
                  hold_len: dahdsr_pkg::HoldRst, decay_len: dahdsr_pkg::DecayRst,
                  sustain_len: dahdsr_pkg::SustainRst, release_len: dahdsr_pkg::ReleaseRst,
                  sus_level: dahdsr_pkg::LevelRst};
    // boundaries after reset: 20, 140, 210, 385, 685, release ends at 985
    dir_rows = '{
      '{24'd0,        24'd0,        1'b1, '{15'd0,     1'b0, dahdsr_pkg::StDelay}},
      '{24'd0,        24'd1,        1'b1, '{15'd0,     1'b1, dahdsr_pkg::StDelay}},
      '{24'd19,       24'd20,       1'b1, '{15'd0,     1'b1, dahdsr_pkg::StDelay}},
      '{24'd20,       24'd20,       1'b1, '{15'd0,     1'b0, dahdsr_pkg::StAttack}},
      '{24'd80,       24'd1000,     1'b0, '0},
      '{24'd139,      24'd139,      1'b0, '0},
      '{24'd140,      24'hFF_FFFF,  1'b1, '{15'd16384, 1'b1, dahdsr_pkg::StHold}},
      '{24'd209,      24'd300,      1'b0, '0},
      '{24'd210,      24'd211,      1'b1, '{15'd16384, 1'b1, dahdsr_pkg::StDecay}},
      '{24'd300,      24'd5,        1'b0, '0},
      '{24'd384,      24'd385,      1'b0, '0},
      '{24'd385,      24'd1000,     1'b1, '{15'd8192,  1'b1, dahdsr_pkg::StSustain}},
      '{24'd684,      24'd684,      1'b0, '0},
      '{24'd685,      24'd1000,     1'b1, '{15'd8192,  1'b1, dahdsr_pkg::StRelease}},
      '{24'd800,      24'd900,      1'b0, '0},
      '{24'd984,      24'd985,      1'b0, '0},
      '{24'd985,      24'd2000,     1'b1, '{15'd0,     1'b1, dahdsr_pkg::StRelease}},
      '{24'hFF_FFFF,  24'hFF_FFFF,  1'b1, '{15'd0,     1'b0, dahdsr_pkg::StRelease}},
      '{24'hFF_FFFF,  24'd0,        1'b1, '{15'd0,     1'b0, dahdsr_pkg::StRelease}},
      '{24'd0,        24'hFF_FFFF,  1'b1, '{15'd0,     1'b1, dahdsr_pkg::StDelay}},
      '{24'hAA_AAAA,  24'h55_5555,  1'b0, '0},
      '{24'h55_5555,  24'hAA_AAAA,  1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].offset, dir_rows[i].length, dir_rows[i].typed,
                  dir_rows[i].res);
    end
    run_random(220, 40);
    drain();

    for (p = 1; p <= 8; p++) begin
      case (p)
        1: begin
          // every stage empty, release of zero length
          c = '0;
          lvl = 16'd16384;
        end
        2: begin
          c = '{default: '1};
          lvl = 16'hFFFF;
        end
        3: begin
          c = '{delay_len: 16'd1, attack_len: 16'd1, hold_len: 16'd1, decay_len: 16'd1,
                sustain_len: 16'd1, release_len: 16'd1, sus_level: '0};
          lvl = 16'd0;
        end
        default: begin
          c.delay_len   = rand_len();
          c.attack_len  = rand_len();
          c.hold_len    = rand_len();
          c.decay_len   = rand_len();
          c.sustain_len = rand_len();
          c.release_len = rand_len();
          c.sus_level   = '0;
          lvl = rand_level_data();
        end
      endcase
      load_config(c, lvl);
      k = (p == 1) ? 120 : 220;
      run_random(k, (p == 5) ? 50 : -1);
      drain();
    end

    repeat (25) @(posedge clk_i);
    if (err_cnt == 0 && env_due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : sink_seq
    int unsigned wait_n;
    out_stall_i <= 1'b0;
    rx_calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_n = HoldOffCycles;
      end else begin
        wait_n = rx_calm ? 0 : $urandom_range(0, 19);
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
    end
  end

  always @(posedge clk_i) begin : result_check
    env_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (env_due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: env %0d in_note %0b stage %0d",
                   envelope_o, in_note_o, stage_o);
        end
      end else begin
        want = env_due_q.pop_front();
        if (envelope_o !== want.envelope || in_note_o !== want.in_note ||
            stage_o !== want.stage) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected env %0d in_note %0b stage %0d, got %0d %0b %0d",
                     want.envelope, want.in_note, want.stage,
                     envelope_o, in_note_o, stage_o);
          end
        end
      end
    end
  end

  // cycles in which no request moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

[sim.f]
src/dahdsr_pkg.sv
src/dahdsr_front.sv
src/dahdsr_mul.sv
src/dahdsr_div.sv
src/dahdsr_envelope_generator.sv
dv/dahdsr_envelope_generator_test.sv
